[rtl/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// Types, field offsets and codes for the byte-serial tar stream deframer.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned OFS_BITS    = $clog2(BLOCK_BYTES);
  localparam int unsigned SIZE_BITS   = 33;
  localparam int unsigned MODE_BITS   = 21;
  localparam int unsigned CSUM_BITS   = 24;
  localparam int unsigned USUM_BITS   = 17;
  localparam int unsigned SSUM_BITS   = 18;

  // Header field offsets
  localparam logic [OFS_BITS-1:0] MODE_AT   = OFS_BITS'(100);
  localparam logic [OFS_BITS-1:0] MODE_LAST = OFS_BITS'(107);
  localparam logic [OFS_BITS-1:0] SIZE_AT   = OFS_BITS'(124);
  localparam logic [OFS_BITS-1:0] SIZE_LAST = OFS_BITS'(135);
  localparam logic [OFS_BITS-1:0] SUM_AT    = OFS_BITS'(148);
  localparam logic [OFS_BITS-1:0] SUM_LAST  = OFS_BITS'(155);
  localparam logic [OFS_BITS-1:0] TYPE_AT   = OFS_BITS'(156);
  localparam logic [OFS_BITS-1:0] HDR_LAST  = OFS_BITS'(BLOCK_BYTES - 1);

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] DIGIT_0    = 8'h30;
  localparam logic [7:0] DIGIT_7    = 8'h37;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [2:0] {
    KIND_HDR_BYTE = 3'd0,
    KIND_HDR_OK   = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_PADDING  = 3'd3,
    KIND_CSUM_BAD = 3'd4,
    KIND_IGNORED  = 3'd5,
    KIND_RESTART  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_PADDING = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    OCT_SKIP   = 3'b001,
    OCT_DIGITS = 3'b010,
    OCT_DONE   = 3'b100
  } oct_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [7:0]           out_byte;
    logic [SIZE_BITS-1:0] file_size;
    logic [7:0]           file_type;
    logic [MODE_BITS-1:0] file_mode;
    logic                 last_of_file;
  } result_t;

endpackage

[rtl/tar_stream_deframer_top.sv]
// ----------------------------------------------------------------------------
// tar_stream_deframer_top
// Byte-serial ustar deframer: header check, payload pass-through, pad skip.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_ready carries one archive byte or a
// restart request (op). Every request gives exactly one result on
// result/result_valid/result_ready: header byte, header accepted (with size,
// type flag and mode), payload byte (last_of_file on the final one), padding,
// checksum failure, ignored-in-error or restart acknowledge.
// All per-byte work (running sums, octal field parsing, counters) is done in
// the cycle a request is accepted; the result is registered, and a new
// request can be taken every cycle while the skid register is empty.
// A two-entry output stage (result register plus skid register) lets the
// block take one more request while a result is still waiting; item_ready
// drops only when both entries are full, i.e. while the receiver stalls.
// Reset (rst, synchronous) empties the output stage, clears the error and
// puts the block in front of a header at block offset zero. A checksum
// failure is sticky until a restart request arrives.
// ----------------------------------------------------------------------------
module tar_stream_deframer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tsd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output tsd_pkg::result_t result
);

  // Deframer state
  tsd_pkg::phase_t                  phase, phase_next;
  logic [tsd_pkg::OFS_BITS-1:0]     block_offset, block_offset_next;
  logic [tsd_pkg::SIZE_BITS-1:0]    payload_left, payload_left_next;
  logic [tsd_pkg::USUM_BITS-1:0]    sum_unsigned, sum_unsigned_next;
  logic [tsd_pkg::SSUM_BITS-1:0]    sum_signed, sum_signed_next;
  logic [tsd_pkg::CSUM_BITS-1:0]    checksum_value, checksum_value_next;
  logic [tsd_pkg::SIZE_BITS-1:0]    size_value, size_value_next;
  logic [tsd_pkg::MODE_BITS-1:0]    mode_value, mode_value_next;
  tsd_pkg::oct_t                    oct_state, oct_state_next;
  logic [7:0]                       type_byte, type_byte_next;
  logic                             error_flag, error_flag_next;

  // Output stage
  tsd_pkg::result_t res_next;
  tsd_pkg::result_t skid;
  logic             skid_valid;

  logic push, pop;

  assign item_ready = !skid_valid;
  assign push       = item_valid && item_ready;
  assign pop        = result_valid && result_ready;

  // Per-byte combinational update
  logic [7:0]                    b;
  logic [7:0]                    v;
  logic [2:0]                    digit;
  logic                          is_digit;
  logic                          feed;
  logic                          in_mode, in_size, in_sum;
  tsd_pkg::oct_t                 oct_cur;
  logic [tsd_pkg::OFS_BITS-1:0]  ofs_inc;
  logic                          csum_match;

  always_comb begin
    b        = item.data_byte;
    digit    = b[2:0];
    is_digit = (b >= tsd_pkg::DIGIT_0) && (b <= tsd_pkg::DIGIT_7);
    ofs_inc  = block_offset + tsd_pkg::OFS_BITS'(1);
    in_mode  = (block_offset >= tsd_pkg::MODE_AT) && (block_offset <= tsd_pkg::MODE_LAST);
    in_size  = (block_offset >= tsd_pkg::SIZE_AT) && (block_offset <= tsd_pkg::SIZE_LAST);
    in_sum   = (block_offset >= tsd_pkg::SUM_AT) && (block_offset <= tsd_pkg::SUM_LAST);

    phase_next          = phase;
    block_offset_next   = block_offset;
    payload_left_next   = payload_left;
    sum_unsigned_next   = sum_unsigned;
    sum_signed_next     = sum_signed;
    checksum_value_next = checksum_value;
    size_value_next     = size_value;
    mode_value_next     = mode_value;
    oct_state_next      = oct_state;
    type_byte_next      = type_byte;
    error_flag_next     = error_flag;

    res_next      = '0;
    oct_cur       = oct_state;
    feed          = 1'b0;
    v             = b;
    csum_match    = 1'b0;

    if (item.op == tsd_pkg::OP_RESTART) begin
      res_next.kind       = tsd_pkg::KIND_RESTART;
      phase_next          = tsd_pkg::PH_HEADER;
      block_offset_next   = '0;
      payload_left_next   = '0;
      sum_unsigned_next   = '0;
      sum_signed_next     = '0;
      checksum_value_next = '0;
      size_value_next     = '0;
      mode_value_next     = '0;
      oct_state_next      = tsd_pkg::OCT_SKIP;
      type_byte_next      = '0;
      error_flag_next     = 1'b0;
    end else if (error_flag) begin
      res_next.kind = tsd_pkg::KIND_IGNORED;
    end else begin
      case (phase)
        tsd_pkg::PH_PAYLOAD: begin
          res_next.kind     = tsd_pkg::KIND_PAYLOAD;
          res_next.out_byte = b;
          payload_left_next = payload_left - tsd_pkg::SIZE_BITS'(1);
          block_offset_next = ofs_inc;
          if (payload_left_next == '0) begin
            res_next.last_of_file = 1'b1;
            phase_next = (ofs_inc == '0) ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PADDING;
            if (ofs_inc == '0) begin
              sum_unsigned_next   = '0;
              sum_signed_next     = '0;
              checksum_value_next = '0;
              size_value_next     = '0;
              mode_value_next     = '0;
              oct_state_next      = tsd_pkg::OCT_SKIP;
              type_byte_next      = '0;
            end
          end
        end
        tsd_pkg::PH_PADDING: begin
          res_next.kind     = tsd_pkg::KIND_PADDING;
          block_offset_next = ofs_inc;
          if (ofs_inc == '0) begin
            phase_next          = tsd_pkg::PH_HEADER;
            sum_unsigned_next   = '0;
            sum_signed_next     = '0;
            checksum_value_next = '0;
            size_value_next     = '0;
            mode_value_next     = '0;
            oct_state_next      = tsd_pkg::OCT_SKIP;
            type_byte_next      = '0;
          end
        end
        default: begin
          // Header byte: a field start re-arms the octal parser
          if (block_offset == tsd_pkg::MODE_AT || block_offset == tsd_pkg::SIZE_AT ||
              block_offset == tsd_pkg::SUM_AT) begin
            oct_cur = tsd_pkg::OCT_SKIP;
          end
          oct_state_next = oct_cur;
          if (in_mode || in_size || in_sum) begin
            if (oct_cur == tsd_pkg::OCT_DONE) begin
              feed = 1'b0;
            end else if (oct_cur == tsd_pkg::OCT_SKIP && b == tsd_pkg::SPACE_BYTE) begin
              feed = 1'b0;
            end else if (is_digit) begin
              feed           = 1'b1;
              oct_state_next = tsd_pkg::OCT_DIGITS;
            end else begin
              oct_state_next = tsd_pkg::OCT_DONE;
            end
          end

          // Octal accumulate, saturating once any of the top three bits is set
          if (feed && in_mode) begin
            if (mode_value[tsd_pkg::MODE_BITS-1 -: 3] != 3'b000) begin
              mode_value_next = '1;
            end else begin
              mode_value_next = {mode_value[tsd_pkg::MODE_BITS-4:0], digit};
            end
          end
          if (feed && in_size) begin
            if (size_value[tsd_pkg::SIZE_BITS-1 -: 3] != 3'b000) begin
              size_value_next = '1;
            end else begin
              size_value_next = {size_value[tsd_pkg::SIZE_BITS-4:0], digit};
            end
          end
          if (feed && in_sum) begin
            if (checksum_value[tsd_pkg::CSUM_BITS-1 -: 3] != 3'b000) begin
              checksum_value_next = '1;
            end else begin
              checksum_value_next = {checksum_value[tsd_pkg::CSUM_BITS-4:0], digit};
            end
          end

          if (in_sum) begin
            v = tsd_pkg::SPACE_BYTE;
          end
          if (block_offset == tsd_pkg::TYPE_AT) begin
            type_byte_next = b;
          end
          sum_unsigned_next = sum_unsigned + tsd_pkg::USUM_BITS'(v);
          sum_signed_next   = sum_signed +
                              {{(tsd_pkg::SSUM_BITS-8){v[7]}}, v};

          if (block_offset == tsd_pkg::HDR_LAST) begin
            csum_match =
              (checksum_value_next ==
               tsd_pkg::CSUM_BITS'(sum_unsigned_next)) ||
              (!sum_signed_next[tsd_pkg::SSUM_BITS-1] &&
               checksum_value_next == tsd_pkg::CSUM_BITS'(sum_signed_next));
            if (csum_match) begin
              res_next.kind      = tsd_pkg::KIND_HDR_OK;
              res_next.file_size = size_value_next;
              res_next.file_type = type_byte_next;
              res_next.file_mode = mode_value_next;
              payload_left_next  = size_value_next;
              block_offset_next  = '0;
              if (size_value_next == '0) begin
                phase_next          = tsd_pkg::PH_HEADER;
                sum_unsigned_next   = '0;
                sum_signed_next     = '0;
                checksum_value_next = '0;
                size_value_next     = '0;
                mode_value_next     = '0;
                oct_state_next      = tsd_pkg::OCT_SKIP;
                type_byte_next      = '0;
              end else begin
                phase_next = tsd_pkg::PH_PAYLOAD;
              end
            end else begin
              res_next.kind     = tsd_pkg::KIND_CSUM_BAD;
              error_flag_next   = 1'b1;
              block_offset_next = '0;
            end
          end else begin
            res_next.kind     = tsd_pkg::KIND_HDR_BYTE;
            block_offset_next = ofs_inc;
          end
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tsd_pkg::PH_HEADER;
      block_offset   <= '0;
      payload_left   <= '0;
      sum_unsigned   <= '0;
      sum_signed     <= '0;
      checksum_value <= '0;
      size_value     <= '0;
      mode_value     <= '0;
      oct_state      <= tsd_pkg::OCT_SKIP;
      type_byte      <= '0;
      error_flag     <= 1'b0;
    end else if (push) begin
      phase          <= phase_next;
      block_offset   <= block_offset_next;
      payload_left   <= payload_left_next;
      sum_unsigned   <= sum_unsigned_next;
      sum_signed     <= sum_signed_next;
      checksum_value <= checksum_value_next;
      size_value     <= size_value_next;
      mode_value     <= mode_value_next;
      oct_state      <= oct_state_next;
      type_byte      <= type_byte_next;
      error_flag     <= error_flag_next;
    end
  end

  // Output stage: result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (pop || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !result_valid) begin
      result <= skid_valid ? skid : res_next;
    end
    if (push && result_valid && !pop) begin
      skid <= res_next;
    end
  end

  // Checks
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a pending result");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == tsd_pkg::PH_PAYLOAD) |-> (payload_left != '0))
    else $error("payload phase with no bytes left");

  a_error_in_header: assert property (@(posedge clk) disable iff (rst)
    error_flag |-> (phase == tsd_pkg::PH_HEADER))
    else $error("error flag set outside header phase");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (push && item.op == tsd_pkg::OP_RESTART) |=> (!error_flag && block_offset == '0))
    else $error("restart did not clear error and offset");

endmodule
